/* sv/time_request_retry_scheduler_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the time request retry scheduler
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TIME_REQUEST_RETRY_SCHEDULER_ASSERT_SVH
`define TIME_REQUEST_RETRY_SCHEDULER_ASSERT_SVH

`ifndef SYNTHESIS
// Implication that must hold at every clock edge outside reset.
`define TRRS_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("trrs assertion failed");
// Condition that must never be true outside reset.
`define TRRS_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("trrs forbidden condition seen");
`else
`define TRRS_ASSERT(name, prop)
`define TRRS_ASSERT_NEVER(name, cond)
`endif

`endif

/* sv/trrs_pkg.sv */
// ----------------------------------------------------------------------------
// trrs_pkg
// Types, codes and constants shared by the time request retry scheduler.
// ----------------------------------------------------------------------------
package trrs_pkg;

  localparam int unsigned OpW      = 3;
  localparam int unsigned MsW      = 32;
  localparam int unsigned EpochW   = 63;
  localparam int unsigned AttW     = 4;
  localparam int unsigned RetryW   = 20;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  // Division by 1000 of a 32-bit value: (x * 274877907) >> 38 is exact.
  localparam int unsigned RecipW   = 29;
  localparam logic [RecipW-1:0] MS_RECIP = 29'd274877907;
  localparam int unsigned RecipShift = 38;
  localparam int unsigned ProdW    = MsW + RecipW;
  localparam int unsigned SecsW    = ProdW - RecipShift;

  localparam logic [AttW-1:0]   ATT_SAT   = 4'd15;
  localparam logic [EpochW-1:0] EPOCH_MAX = {EpochW{1'b1}};

  typedef enum logic [OpW-1:0] {
    OP_TICK         = 3'd0,
    OP_CONNECTED    = 3'd1,
    OP_DISCONNECTED = 3'd2,
    OP_TIME_RX      = 3'd3,
    OP_MANUAL       = 3'd4
  } op_e;

  localparam logic [CfgIdxW-1:0] CFG_RETRY_INTERVAL = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_ATTEMPTS   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_RESYNC_PERIOD  = 2'd2;

  localparam logic [RetryW-1:0] RETRY_RESET  = 20'd7000;
  localparam logic [AttW-1:0]   MAX_ATT_RESET = 4'd5;
  localparam logic [MsW-1:0]    RESYNC_RESET = 32'd60000;

  typedef struct packed {
    logic [RetryW-1:0] retry_interval_ms;
    logic [AttW-1:0]   max_attempts;
    logic [MsW-1:0]    resync_period_ms;
  } cfg_t;

  typedef struct packed {
    logic [OpW-1:0]    opcode;
    logic [MsW-1:0]    now_ms;
    logic              link_ready;
    logic              can_send;
    logic [EpochW-1:0] host_epoch;
  } item_t;

  // Outcome of one event, before the epoch is advanced.
  typedef struct packed {
    logic              send_request;
    logic              have_time;
    logic              awaiting_reply;
    logic [AttW-1:0]   attempts;
    logic [EpochW-1:0] stored_epoch;
    logic [MsW-1:0]    elapsed_ms;
  } step_res_t;

endpackage

/* sv/trrs_sched.sv */
// ----------------------------------------------------------------------------
// trrs_sched
// Scheduler state and the decision logic for one event.
// ----------------------------------------------------------------------------
module trrs_sched import trrs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  item_t     item_i,
  input  logic      step_i,
  output step_res_t res_o
);

  typedef struct packed {
    logic            waiting;
    logic [MsW-1:0]  last_req;
    logic [AttW-1:0] att;
    logic            sent;
  } issue_t;

  logic [EpochW-1:0] epoch_q, epoch_d;
  logic              valid_q, valid_d;
  logic              wait_q, wait_d;
  logic [AttW-1:0]   att_q, att_d;
  logic [MsW-1:0]    lreq_q, lreq_d;
  logic [MsW-1:0]    lsync_q, lsync_d;

  logic [MsW-1:0]    retry_ext;
  logic [MsW-1:0]    cool_ms;
  logic [MsW-1:0]    since_sync;
  logic [MsW-1:0]    since_req;
  logic              c_resync, c_first, c_retry, c_cool;
  issue_t            iss_cur, iss_zero;

  function automatic issue_t issue(input logic [MsW-1:0] now, input logic can_send,
                                   input logic [AttW-1:0] att,
                                   input logic [MsW-1:0] retry);
    issue_t r;
    r.waiting  = 1'b1;
    r.sent     = can_send;
    r.last_req = can_send ? now : now - retry;
    r.att      = (can_send && (att != ATT_SAT)) ? att + AttW'(1) : att;
    return r;
  endfunction

  assign retry_ext  = MsW'(cfg_i.retry_interval_ms);
  // Four retry intervals fit in 22 bits, so no wrap here.
  assign cool_ms    = {retry_ext[MsW-3:0], 2'b00};
  assign since_sync = item_i.now_ms - lsync_q;
  assign since_req  = item_i.now_ms - lreq_q;

  assign c_resync = valid_q && !wait_q && (since_sync >= cfg_i.resync_period_ms);
  assign c_first  = !valid_q && !wait_q && (att_q == '0);
  assign c_retry  = wait_q && (att_q < cfg_i.max_attempts) && (since_req > retry_ext);
  // A retry in the same tick leaves the request age at zero or one interval,
  // which never passes the cool-down, so this check can use the old state.
  assign c_cool   = wait_q && (att_q >= cfg_i.max_attempts) && (since_req > cool_ms);

  assign iss_cur  = issue(item_i.now_ms, item_i.can_send, att_q, retry_ext);
  assign iss_zero = issue(item_i.now_ms, item_i.can_send, '0, retry_ext);

  always_comb begin
    logic sent;
    sent    = 1'b0;
    epoch_d = epoch_q;
    valid_d = valid_q;
    wait_d  = wait_q;
    att_d   = att_q;
    lreq_d  = lreq_q;
    lsync_d = lsync_q;
    case (item_i.opcode)
      OP_TICK: begin
        if (item_i.link_ready) begin
          if (c_resync || c_first || c_retry) begin
            sent   = iss_cur.sent;
            wait_d = iss_cur.waiting;
            att_d  = iss_cur.att;
            lreq_d = iss_cur.last_req;
          end else if (c_cool) begin
            att_d = '0;
          end
        end
      end
      OP_CONNECTED: begin
        sent   = iss_zero.sent;
        wait_d = iss_zero.waiting;
        att_d  = iss_zero.att;
        lreq_d = iss_zero.last_req;
      end
      OP_DISCONNECTED: begin
        wait_d = 1'b0;
        att_d  = '0;
      end
      OP_TIME_RX: begin
        if (item_i.host_epoch != '0) begin
          epoch_d = item_i.host_epoch;
          valid_d = 1'b1;
          lsync_d = item_i.now_ms;
          wait_d  = 1'b0;
          att_d   = '0;
        end
      end
      OP_MANUAL: begin
        sent   = iss_cur.sent;
        wait_d = iss_cur.waiting;
        att_d  = iss_cur.att;
        lreq_d = iss_cur.last_req;
      end
      default: begin
      end
    endcase
    res_o.send_request   = sent;
    res_o.have_time      = valid_d;
    res_o.awaiting_reply = wait_d;
    res_o.attempts       = att_d;
    res_o.stored_epoch   = epoch_d;
    res_o.elapsed_ms     = item_i.now_ms - lsync_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q <= '0;
      valid_q <= 1'b0;
      wait_q  <= 1'b0;
      att_q   <= '0;
      lreq_q  <= '0;
      lsync_q <= '0;
    end else if (step_i) begin
      epoch_q <= epoch_d;
      valid_q <= valid_d;
      wait_q  <= wait_d;
      att_q   <= att_d;
      lreq_q  <= lreq_d;
      lsync_q <= lsync_d;
    end
  end

endmodule

/* sv/time_request_retry_scheduler.sv */
// ----------------------------------------------------------------------------
// time_request_retry_scheduler
// Holds a host epoch and decides when to send time requests to a link partner.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Contents
//   s_axis    in         one event: opcode in tuser, time and flags in tdata
//   m_axis    out        one result per event: request flag, status, epoch
//   cfg       in         register writes, taken on a rising edge with cfg_we_i high
//
// One event is taken per clock cycle. Each event transfer loads the input
// register; the event then passes the decision stage (scheduler state is
// updated here), the seconds stage (multiply by the reciprocal of 1000) and
// the output register (epoch add with saturation). Each stage loads whenever
// it is empty or its contents move on, so a stalled output only blocks input
// once all four stages are full. Reset clears the scheduler state, the stage
// valid flags and restores the register defaults.

module time_request_retry_scheduler import trrs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Event stream.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata from bit 0: now_ms[31:0], link_ready, can_send, host_epoch[62:0], zero pad
  input  logic [103:0]        s_axis_tdata,
  // tuser from bit 0: opcode[2:0]
  input  logic [OpW-1:0]      s_axis_tuser,
  // Result stream.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata from bit 0: send_request, have_time, awaiting_reply, attempts[3:0],
  // current_epoch[62:0], zero pad
  output logic [71:0]         m_axis_tdata,
  // Configuration writes.
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  `include "time_request_retry_scheduler_assert.svh"

  // Configuration registers.
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.retry_interval_ms <= RETRY_RESET;
      cfg_q.max_attempts      <= MAX_ATT_RESET;
      cfg_q.resync_period_ms  <= RESYNC_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RETRY_INTERVAL: cfg_q.retry_interval_ms <= cfg_data_i[RetryW-1:0];
        CFG_MAX_ATTEMPTS:   cfg_q.max_attempts      <= cfg_data_i[AttW-1:0];
        CFG_RESYNC_PERIOD:  cfg_q.resync_period_ms  <= cfg_data_i[MsW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Stage valid flags and the load enables that ripple back from the output.
  logic in_v_q, s1_v_q, s2_v_q, out_v_q;
  logic in_en, s1_en, s2_en, out_en;

  assign out_en = !out_v_q || m_axis_tready;
  assign s2_en  = !s2_v_q || out_en;
  assign s1_en  = !s1_v_q || s2_en;
  assign in_en  = !in_v_q || s1_en;

  assign s_axis_tready = in_en;
  assign m_axis_tvalid = out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_en)  in_v_q  <= s_axis_tvalid;
      if (s1_en)  s1_v_q  <= in_v_q;
      if (s2_en)  s2_v_q  <= s1_v_q;
      if (out_en) out_v_q <= s2_v_q;
    end
  end

  // Input register: unpack the event.
  item_t item_q;

  always_ff @(posedge clk_i) begin
    if (in_en && s_axis_tvalid) begin
      item_q.opcode     <= s_axis_tuser;
      item_q.now_ms     <= s_axis_tdata[31:0];
      item_q.link_ready <= s_axis_tdata[32];
      item_q.can_send   <= s_axis_tdata[33];
      item_q.host_epoch <= s_axis_tdata[96:34];
    end
  end

  // Decision stage. The scheduler state advances exactly when the event
  // leaves the input register, so the next event sees the updated state.
  step_res_t step_res;
  step_res_t s1_q;
  logic      step;

  assign step = in_v_q && s1_en;

  trrs_sched u_sched (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .item_i (item_q),
    .step_i (step),
    .res_o  (step_res)
  );

  always_ff @(posedge clk_i) begin
    if (step) begin
      s1_q <= step_res;
    end
  end

  // Seconds stage: elapsed milliseconds divided by 1000.
  logic [ProdW-1:0]  prod;
  logic              s2_sent_q, s2_have_q, s2_wait_q;
  logic [AttW-1:0]   s2_att_q;
  logic [EpochW-1:0] s2_epoch_q;
  logic [SecsW-1:0]  s2_secs_q;

  assign prod = ProdW'(s1_q.elapsed_ms) * ProdW'(MS_RECIP);

  always_ff @(posedge clk_i) begin
    if (s1_v_q && s2_en) begin
      s2_sent_q  <= s1_q.send_request;
      s2_have_q  <= s1_q.have_time;
      s2_wait_q  <= s1_q.awaiting_reply;
      s2_att_q   <= s1_q.attempts;
      s2_epoch_q <= s1_q.stored_epoch;
      s2_secs_q  <= prod[ProdW-1:RecipShift];
    end
  end

  // Output register: advance the epoch, saturating at the top of its range, or zero without a held epoch.
  logic [EpochW:0]   epoch_sum;
  logic [EpochW-1:0] epoch_cur;
  logic              out_sent_q, out_have_q, out_wait_q;
  logic [AttW-1:0]   out_att_q;
  logic [EpochW-1:0] out_epoch_q;

  assign epoch_sum = {1'b0, s2_epoch_q} + (EpochW + 1)'(s2_secs_q);
  assign epoch_cur = !s2_have_q   ? '0 :
                     epoch_sum[EpochW] ? EPOCH_MAX : epoch_sum[EpochW-1:0];

  always_ff @(posedge clk_i) begin
    if (s2_v_q && out_en) begin
      out_sent_q  <= s2_sent_q;
      out_have_q  <= s2_have_q;
      out_wait_q  <= s2_wait_q;
      out_att_q   <= s2_att_q;
      out_epoch_q <= epoch_cur;
    end
  end

  assign m_axis_tdata = {2'b00, out_epoch_q, out_att_q, out_wait_q, out_have_q, out_sent_q};

  // A sent request always leaves the block waiting with a nonzero count.
  `TRRS_ASSERT(a_sent_waits, (out_v_q && out_sent_q) |-> (out_wait_q && (out_att_q != '0)))
  // Without a held epoch the reported epoch is zero.
  `TRRS_ASSERT(a_no_time_zero, (out_v_q && !out_have_q) |-> (out_epoch_q == '0))
  // A full pipeline with a stalled output must not take another event.
  `TRRS_ASSERT_NEVER(a_full_accept,
      in_v_q && s1_v_q && s2_v_q && out_v_q && !m_axis_tready && s_axis_tready)

endmodule

/* tb/time_request_retry_scheduler_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// time_request_retry_scheduler_checker
// Watches the event, result and register channels of the scheduler, keeps
// its own copy of the scheduler state, and checks every result transfer.
// ----------------------------------------------------------------------------

module time_request_retry_scheduler_checker import trrs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [103:0]        s_tdata_i,
  input  logic [OpW-1:0]      s_tuser_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [71:0]         m_tdata_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o,
  output int unsigned         checked_o,
  output int unsigned         requests_o
);

  localparam logic [MsW-1:0] MS_PER_SEC   = 32'd1000;
  localparam int unsigned    REPORT_LIMIT = 10;

  typedef struct packed {
    logic              send_request;
    logic              have_time;
    logic              awaiting_reply;
    logic [AttW-1:0]   attempts;
    logic [EpochW-1:0] current_epoch;
  } status_t;

  // Register copies.
  logic [RetryW-1:0] retry_ms;
  logic [AttW-1:0]   att_cap;
  logic [MsW-1:0]    resync_ms;

  // Scheduler state copies.
  logic [EpochW-1:0] epoch_held;
  logic              time_held;
  logic              awaiting;
  logic [AttW-1:0]   attempt_cnt;
  logic [MsW-1:0]    req_stamp;
  logic [MsW-1:0]    sync_stamp;

  status_t expected_status_q[$];

  // A request always marks the scheduler as waiting. When it cannot go out,
  // its time stamp is moved back one interval so that the next tick retries.
  function automatic logic issue_time_request(input logic [MsW-1:0] now,
                                              input logic cs);
    awaiting = 1'b1;
    if (!cs) begin
      req_stamp = now - {{(MsW-RetryW){1'b0}}, retry_ms};
      return 1'b0;
    end
    req_stamp = now;
    if (attempt_cnt != ATT_SAT) attempt_cnt = attempt_cnt + 1'b1;
    return 1'b1;
  endfunction

  function automatic logic run_tick(input logic [MsW-1:0] now, input logic cs);
    logic [MsW-1:0] since_sync;
    logic [MsW-1:0] since_req;
    logic [MsW-1:0] retry_wide;
    logic [MsW-1:0] cooldown_ms;
    logic           sent;
    sent        = 1'b0;
    since_sync  = now - sync_stamp;
    retry_wide  = {{(MsW-RetryW){1'b0}}, retry_ms};
    cooldown_ms = retry_wide << 2;
    // Periodic resync and the very first request both end the tick.
    if (time_held && !awaiting && since_sync >= resync_ms)
      return issue_time_request(now, cs);
    if (!time_held && !awaiting && attempt_cnt == '0)
      return issue_time_request(now, cs);
    since_req = now - req_stamp;
    if (awaiting && attempt_cnt < att_cap && since_req > retry_wide)
      sent = issue_time_request(now, cs);
    // The cool-down check sees the stamp and count left by the retry.
    since_req = now - req_stamp;
    if (awaiting && attempt_cnt >= att_cap && since_req > cooldown_ms)
      attempt_cnt = '0;
    return sent;
  endfunction

  function automatic status_t predict_status(input logic [OpW-1:0]    op,
                                             input logic [MsW-1:0]    now,
                                             input logic              link,
                                             input logic              cs,
                                             input logic [EpochW-1:0] host_epoch);
    status_t        res;
    logic [MsW-1:0] secs;
    logic [63:0]    sum;
    res = '0;
    case (op)
      OP_TICK: begin
        if (link) res.send_request = run_tick(now, cs);
      end
      OP_CONNECTED: begin
        attempt_cnt = '0;
        awaiting    = 1'b0;
        res.send_request = issue_time_request(now, cs);
      end
      OP_DISCONNECTED: begin
        attempt_cnt = '0;
        awaiting    = 1'b0;
      end
      OP_TIME_RX: begin
        if (host_epoch != '0) begin
          epoch_held  = host_epoch;
          time_held   = 1'b1;
          sync_stamp  = now;
          awaiting    = 1'b0;
          attempt_cnt = '0;
        end
      end
      OP_MANUAL: begin
        res.send_request = issue_time_request(now, cs);
      end
      default: ;
    endcase
    res.have_time      = time_held;
    res.awaiting_reply = awaiting;
    res.attempts       = attempt_cnt;
    if (time_held) begin
      secs = (now - sync_stamp) / MS_PER_SEC;
      sum  = {1'b0, epoch_held} + {32'd0, secs};
      res.current_epoch = (sum > {1'b0, EPOCH_MAX}) ? EPOCH_MAX : sum[EpochW-1:0];
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    status_t want;
    status_t got;
    if (!rst_ni) begin
      retry_ms     = RETRY_RESET;
      att_cap      = MAX_ATT_RESET;
      resync_ms    = RESYNC_RESET;
      epoch_held   = '0;
      time_held    = 1'b0;
      awaiting     = 1'b0;
      attempt_cnt  = '0;
      req_stamp    = '0;
      sync_stamp   = '0;
      fail_count_o = 0;
      checked_o    = 0;
      requests_o   = 0;
      expected_status_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RETRY_INTERVAL: retry_ms  = cfg_data_i[RetryW-1:0];
          CFG_MAX_ATTEMPTS:   att_cap   = cfg_data_i[AttW-1:0];
          CFG_RESYNC_PERIOD:  resync_ms = cfg_data_i[MsW-1:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        want = predict_status(s_tuser_i, s_tdata_i[31:0], s_tdata_i[32],
                              s_tdata_i[33], s_tdata_i[96:34]);
        if (want.send_request) requests_o++;
        expected_status_q.push_back(want);
      end
      if (m_tvalid_i && m_tready_i) begin
        got.send_request   = m_tdata_i[0];
        got.have_time      = m_tdata_i[1];
        got.awaiting_reply = m_tdata_i[2];
        got.attempts       = m_tdata_i[6:3];
        got.current_epoch  = m_tdata_i[69:7];
        if (expected_status_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= REPORT_LIMIT)
            $display("%0t: result transfer with no event waiting for it", $realtime);
        end else begin
          want = expected_status_q.pop_front();
          checked_o++;
          if (got !== want) begin
            fail_count_o++;
            if (fail_count_o <= REPORT_LIMIT) begin
              $display("%0t: result mismatch, expected send=%0b have=%0b wait=%0b att=%0d epoch=%0d",
                       $realtime, want.send_request, want.have_time,
                       want.awaiting_reply, want.attempts, want.current_epoch);
              $display("%0t:                  actual   send=%0b have=%0b wait=%0b att=%0d epoch=%0d",
                       $realtime, got.send_request, got.have_time,
                       got.awaiting_reply, got.attempts, got.current_epoch);
            end
          end
        end
      end
    end
    pending_o = expected_status_q.size();
  end

endmodule

/* tb/time_request_retry_scheduler_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// time_request_retry_scheduler_tb
// Drives event transfers into the time request retry scheduler under several
// register settings, with bursty input and a stalling result side, and leaves
// the checking to the checker module instantiated beside the block.
// ----------------------------------------------------------------------------

module time_request_retry_scheduler_tb;
  import trrs_pkg::*;

  // Six register settings, each with a random stretch of events. Events the
  // block ignores are not counted towards the stretch length.
  localparam int unsigned NUM_PHASES       = 6;
  localparam int unsigned RANDOM_PER_PHASE = 120;
  // Four pipeline stages sit between an event and its result; the drain
  // wait at the end is longer than the pipeline.
  localparam int unsigned DRAIN_CYCLES     = 8;
  localparam int unsigned LIMIT_CYCLES     = 400000;
  // Opcodes above the manual request carry no meaning for the block.
  localparam logic [OpW-1:0] OP_FIRST_UNUSED = 3'd5;

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                s_tvalid   = 1'b0;
  logic                s_tready;
  logic [103:0]        s_tdata    = '0;
  logic [OpW-1:0]      s_tuser    = '0;
  logic                m_tvalid;
  logic                m_tready   = 1'b0;
  logic [71:0]         m_tdata;
  logic                cfg_we     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx    = '0;
  logic [CfgDataW-1:0] cfg_data   = '0;

  int unsigned fail_count;
  int unsigned pending_results;
  int unsigned checked_results;
  int unsigned requests_predicted;

  // Stimulus bookkeeping. The register copies here only scale the time steps
  // so that they land next to the interesting thresholds.
  logic [MsW-1:0]    sim_now    = '0;
  logic [MsW-1:0]    sync_stim  = '0;
  logic [RetryW-1:0] cur_retry  = RETRY_RESET;
  logic [MsW-1:0]    cur_resync = RESYNC_RESET;
  int unsigned       events_sent = 0;
  int unsigned       cycle_count = 0;

  time_request_retry_scheduler u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  time_request_retry_scheduler_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending_results),
    .checked_o    (checked_results),
    .requests_o   (requests_predicted)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog. The slowest correct run stays far below this count.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, pending_results);
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side back-pressure. The pattern switches at random between always
  // ready, a coin toss per cycle, and mostly ready with occasional stalls.
  int unsigned rx_mode      = 0;
  int unsigned rx_mode_left = 0;
  int unsigned rx_stall     = 0;

  always @(negedge clk) begin
    logic ready_next;
    if (rx_mode_left == 0) begin
      rx_mode      = $urandom_range(0, 2);
      rx_mode_left = $urandom_range(32, 200);
    end
    rx_mode_left--;
    case (rx_mode)
      0: ready_next = 1'b1;
      1: ready_next = ($urandom_range(0, 1) == 1);
      default: begin
        if (rx_stall != 0) begin
          rx_stall--;
          ready_next = 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
          rx_stall   = $urandom_range(1, 12);
          ready_next = 1'b0;
        end else begin
          ready_next = 1'b1;
        end
      end
    endcase
    m_tready <= rst_n ? ready_next : 1'b0;
  end

  // Presents one event from a falling edge on, holds it until the transfer
  // happens, and returns at the falling edge after it. tvalid stays high, so
  // a following event can go out in the very next cycle if the block is ready.
  task automatic send_event(input logic [OpW-1:0]    op,
                            input logic [MsW-1:0]    now,
                            input logic              link,
                            input logic              cs,
                            input logic [EpochW-1:0] host_epoch);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {7'd0, host_epoch, cs, link, now};
    do @(posedge clk); while (!s_tready);
    events_sent++;
    @(negedge clk);
  endtask

  task automatic pause_sender(input int unsigned gap);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Registers may only change while the block is idle, so the sender stops
  // and every outstanding result is collected first.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_results != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Writes the three registers on consecutive cycles.
  task automatic program_regs(input logic [CfgDataW-1:0] retry_data,
                              input logic [CfgDataW-1:0] cap_data,
                              input logic [CfgDataW-1:0] resync_data);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_RETRY_INTERVAL;
    cfg_data <= retry_data;
    @(negedge clk);
    cfg_idx  <= CFG_MAX_ATTEMPTS;
    cfg_data <= cap_data;
    @(negedge clk);
    cfg_idx  <= CFG_RESYNC_PERIOD;
    cfg_data <= resync_data;
    @(negedge clk);
    cfg_we   <= 1'b0;
    @(negedge clk);
    cur_retry  = retry_data[RetryW-1:0];
    cur_resync = resync_data;
  endtask

  // Picks the time of the next event. Nearly half the steps sit right at the retry,
  // cool-down and resync thresholds, one millisecond either side included;
  // the rest are short, medium or wild jumps that also wrap the counter.
  function automatic logic [MsW-1:0] next_time();
    int unsigned    sel;
    logic [MsW-1:0] iv;
    sel = $urandom_range(0, 99);
    iv  = {{(MsW-RetryW){1'b0}}, cur_retry};
    if (sel < 25)      return sim_now + $urandom_range(0, 3);
    else if (sel < 45) return sim_now + iv + $urandom_range(0, 2) - 1;
    else if (sel < 60) return sim_now + (iv << 2) + $urandom_range(0, 2) - 1;
    else if (sel < 70) return sync_stim + cur_resync + $urandom_range(0, 2) - 1;
    else if (sel < 95) return sim_now + $urandom_range(0, 3000);
    else               return $urandom;
  endfunction

  task automatic random_events(input int unsigned count);
    int unsigned       useful;
    int unsigned       burst_left;
    int unsigned       sel;
    bit                gappy;
    logic [OpW-1:0]    op;
    logic              link;
    logic              cs;
    logic [EpochW-1:0] host_epoch;
    useful     = 0;
    burst_left = 0;
    // A quarter of the stretches run without sender gaps at all.
    gappy = ($urandom_range(0, 3) != 0);
    // Now and then start just below the wrap of the millisecond counter.
    if ($urandom_range(0, 2) == 0) sim_now = 32'hFFFF_FFFF - $urandom_range(0, 100000);
    while (useful < count) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if (gappy) pause_sender($urandom_range(0, 6));
      end
      burst_left--;
      // Ticks dominate, as in real use; link events, syncs and manual
      // requests mix in, with a little noise from unused opcodes.
      sel = $urandom_range(0, 99);
      if (sel < 55)      op = OP_TICK;
      else if (sel < 63) op = OP_CONNECTED;
      else if (sel < 68) op = OP_DISCONNECTED;
      else if (sel < 80) op = OP_TIME_RX;
      else if (sel < 94) op = OP_MANUAL;
      else               op = OP_FIRST_UNUSED + OpW'($urandom_range(0, 2));
      link = ($urandom_range(0, 99) < 85);
      cs   = ($urandom_range(0, 99) < 80);
      sel  = $urandom_range(0, 99);
      if (sel < 10)      host_epoch = '0;
      else if (sel < 18) host_epoch = EPOCH_MAX - $urandom_range(0, 5000);
      else               host_epoch = EpochW'({$urandom, $urandom});
      sim_now = next_time();
      send_event(op, sim_now, link, cs, host_epoch);
      if (op == OP_TIME_RX && host_epoch != '0) sync_stim = sim_now;
      if (!((op == OP_TICK && !link) || op > OP_MANUAL ||
            (op == OP_TIME_RX && host_epoch == '0)))
        useful++;
    end
  endtask

  // Opening sequence under the reset register values (retry 7000 ms, five
  // attempts, resync 60 s), aimed at each special case in turn.
  task automatic directed_events();
    logic [MsW-1:0] t;
    // A tick without a link does nothing.
    send_event(OP_TICK, 32'd0, 1'b0, 1'b1, '0);
    // First request while sending is blocked: back-dated, so the next tick
    // retries at once.
    send_event(OP_TICK, 32'd100, 1'b1, 1'b0, '0);
    send_event(OP_TICK, 32'd101, 1'b1, 1'b1, '0);
    // Exactly one interval later is not yet a timeout; one more is.
    send_event(OP_TICK, 32'd7101, 1'b1, 1'b1, '0);
    send_event(OP_TICK, 32'd7102, 1'b1, 1'b1, '0);
    // Retries until the cap, then the four-interval cool-down clears it.
    t = 32'd7102;
    repeat (4) begin
      t = t + 32'd7001;
      send_event(OP_TICK, t, 1'b1, 1'b1, '0);
    end
    send_event(OP_TICK, t + 32'd28000, 1'b1, 1'b1, '0);
    send_event(OP_TICK, t + 32'd28001, 1'b1, 1'b1, '0);
    // Manual requests, one blocked, and a zero epoch that must be ignored.
    send_event(OP_MANUAL, t + 32'd28002, 1'b0, 1'b1, '0);
    send_event(OP_MANUAL, t + 32'd28003, 1'b1, 1'b0, '0);
    send_event(OP_TIME_RX, t + 32'd28004, 1'b1, 1'b1, '0);
    // A sync just below the counter wrap with an epoch near the top, then a
    // tick past the wrap where the advanced epoch saturates.
    send_event(OP_TIME_RX, 32'hFFFF_F000, 1'b1, 1'b1, EPOCH_MAX - 2);
    send_event(OP_TICK, 32'hFFFF_F000 + 32'd5000, 1'b1, 1'b1, '0);
    // The resync period is reached exactly, across the wrap.
    send_event(OP_TICK, 32'hFFFF_F000 + 32'd59999, 1'b1, 1'b1, '0);
    send_event(OP_TICK, 32'hFFFF_F000 + 32'd60000, 1'b1, 1'b1, '0);
    // Link events ignore link_ready; unused opcodes only report the state.
    send_event(OP_CONNECTED, 32'hFFFF_FFFF, 1'b0, 1'b0, EPOCH_MAX);
    send_event(OP_DISCONNECTED, 32'h0000_0000, 1'b1, 1'b1, EPOCH_MAX);
    for (int k = 0; k < 3; k++)
      send_event(OP_FIRST_UNUSED + OpW'(k), 32'hFFFF_FFFF, 1'b1, 1'b1, EPOCH_MAX);
    // Largest epoch, then the longest possible elapsed time.
    send_event(OP_TIME_RX, 32'h0000_0000, 1'b1, 1'b1, EPOCH_MAX);
    send_event(OP_TICK, 32'hFFFF_FFFF, 1'b1, 1'b1, '0);
    send_event(OP_TIME_RX, 32'hFFFF_FFFF, 1'b0, 1'b0, {{(EpochW-1){1'b0}}, 1'b1});
    sim_now   = 32'hFFFF_FFFF;
    sync_stim = 32'hFFFF_FFFF;
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 0) begin
        directed_events();
      end else begin
        drain_results();
        case (ph)
          // Smallest nonzero values: one-millisecond interval, a single attempt,
          // resync due one millisecond after every sync.
          1: program_regs(32'd1, 32'd1, 32'd1);
          // Largest values every register can hold.
          2: program_regs(32'h000F_FFFF, 32'd15, 32'hFFFF_FFFF);
          // Zero interval, zero cap and zero resync period.
          3: program_regs(32'd0, 32'd0, 32'd0);
          4: program_regs($urandom_range(1, 20000), $urandom_range(1, 15),
                          $urandom_range(1, 100000));
          // Raw data words; bits above each register width are dropped.
          default: program_regs($urandom, $urandom, $urandom_range(1, 200000));
        endcase
      end
      random_events(RANDOM_PER_PHASE);
    end

    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_results != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d events under %0d register settings, including the extremes,",
             events_sent, NUM_PHASES);
    $display("and checked %0d results, %0d of which carried a time request.",
             checked_results, requests_predicted);
    if (fail_count == 0 && pending_results == 0) begin
      $display("All tests passed");
    end else begin
      if (pending_results != 0)
        $display("%0d expected results never arrived", pending_results);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
